>>> rtl/core/ewbh_pkg.sv
// Shared types and constants for the equal-width byte histogram.
// Used by equal_width_byte_histogram_unit; depends on nothing.
package ewbh_pkg;

	localparam int MAX_BINS_DEF = 8;
	localparam int FEW_BINS     = 4;
	localparam int COUNT_WIDTH  = 8;
	localparam int SAMPLE_W     = 8;
	localparam int BIN_INDEX_W  = 3;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 8;

	// Bin width is the span times a rounded-up reciprocal of the bin count.
	// For spans up to 256 and counts of 4 to 8 this is exact.
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 15;
	localparam int PROD_W      = 23;
	localparam int WID_W       = 7;
	localparam int EDGE_W      = 10;
	localparam logic [RECIP_W-1:0] RECIP_FEW =
		RECIP_W'((2**RECIP_SHIFT + FEW_BINS - 1) / FEW_BINS);

	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BIN_MODE   = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST  = -8'sd128;
	localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST = 8'sd127;
	localparam logic BIN_MODE_RST = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} ewbh_req_t;

	typedef struct packed {
		logic [BIN_INDEX_W-1:0] bin_index;
		logic [COUNT_WIDTH-1:0] bin_count;
		logic                   last_bin;
	} ewbh_rsp_t;

endpackage

>>> rtl/core/ewbh_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents. No dependencies.
module ewbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/equal_width_byte_histogram_unit.sv
// Equal-width byte histogram: counts signed samples into 4 or MAX_BINS bins.
// Depends on ewbh_pkg and ewbh_ram.
//
// Requests arrive on req_valid/req_stall/req; bin results leave on
// rsp_valid/rsp_stall/rsp. Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while no data set is in
// progress, as the block does not enforce this. A sample is accepted every
// cycle unless req_stall is high. Each sample passes through a reciprocal
// multiply for the bin width, an edge compare that picks the bin, and a
// read-modify-write of a counter RAM with a forward of the previous write.
// Counters live in two RAM banks; a last sample swaps banks, so the next
// data set streams in while the finished bank is read out and cleared, one
// bin per cycle while the output buffer has room, over all MAX_BINS counters.
// A second last sample is held off (req_stall) until the previous read-out
// has swept its bank. After reset both banks are cleared, during which
// req_stall is high. When rsp_stall is high, results wait in a two-entry
// output buffer and the read-out pauses; samples keep being counted.
module equal_width_byte_histogram_unit #(
	parameter int MAX_BINS = ewbh_pkg::MAX_BINS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ewbh_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ewbh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  ewbh_pkg::ewbh_req_t                  req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output ewbh_pkg::ewbh_rsp_t                  rsp
);

	localparam int IDX_W   = $clog2(MAX_BINS);
	localparam int BIN_W   = ewbh_pkg::BIN_INDEX_W;
	localparam int CNT_W   = ewbh_pkg::COUNT_WIDTH;
	localparam int RECIP_W = ewbh_pkg::RECIP_W;
	localparam int PROD_W  = ewbh_pkg::PROD_W;
	localparam int WID_W   = ewbh_pkg::WID_W;
	localparam int EDGE_W  = ewbh_pkg::EDGE_W;
	localparam int SMP_W   = ewbh_pkg::SAMPLE_W;
	localparam logic [RECIP_W-1:0] RECIP_MAX =
		RECIP_W'((2**ewbh_pkg::RECIP_SHIFT + MAX_BINS - 1) / MAX_BINS);
	localparam logic [IDX_W-1:0] LAST_PTR     = IDX_W'(MAX_BINS - 1);
	localparam logic [IDX_W-1:0] LAST_PTR_FEW = IDX_W'(ewbh_pkg::FEW_BINS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	// Configuration registers
	logic signed [SMP_W-1:0] range_low_q;
	logic signed [SMP_W-1:0] range_high_q;
	logic                    bin_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= ewbh_pkg::RANGE_LOW_RST;
			range_high_q <= ewbh_pkg::RANGE_HIGH_RST;
			bin_mode_q   <= ewbh_pkg::BIN_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ewbh_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_data;
				ewbh_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_data;
				ewbh_pkg::CFG_BIN_MODE:   bin_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	state_t           state_q;
	logic [IDX_W-1:0] ptr_q;
	logic             drain_bank_q;
	logic             drain_mode_q;
	logic             bank_q;

	// Pipeline registers
	logic             v_s1, en_s1, last_s1, bank_s1, mode_s1;
	logic [SMP_W-1:0] dist_s1;
	logic [WID_W-1:0] width_s1;
	logic             v_s2, en_s2, last_s2, bank_s2, mode_s2;
	logic [IDX_W-1:0] bin_s2;

	logic             fwd_v_q, fwd_bank_q;
	logic [IDX_W-1:0] fwd_addr_q;
	logic [CNT_W-1:0] fwd_data_q;

	// Output buffer and the read-out in flight
	logic                infl_v_q, infl_bank_q, infl_last_q;
	logic [IDX_W-1:0]    infl_idx_q;
	logic                out_v_q, skid_v_q;
	ewbh_pkg::ewbh_rsp_t out_q, skid_q, push_data;

	logic             ram_we    [2];
	logic [IDX_W-1:0] ram_waddr [2];
	logic [CNT_W-1:0] ram_wdata [2];
	logic [IDX_W-1:0] ram_raddr [2];
	logic [CNT_W-1:0] ram_rdata [2];

	// Stage 0: range check and bin width
	logic signed [SMP_W:0] smp_x, lo_x, hi_x, diff_x;
	logic                  in_range;
	logic [SMP_W:0]        span;
	logic [RECIP_W-1:0]    recip;
	logic [PROD_W-1:0]     prod;
	logic                  req_acc;
	logic                  last_busy;

	assign smp_x    = {req.sample[SMP_W-1], req.sample};
	assign lo_x     = {range_low_q[SMP_W-1], range_low_q};
	assign hi_x     = {range_high_q[SMP_W-1], range_high_q};
	assign diff_x   = smp_x - lo_x;
	assign in_range = (lo_x <= hi_x) && (smp_x >= lo_x) && (smp_x <= hi_x);
	assign span     = (SMP_W + 1)'(hi_x - lo_x) + (SMP_W + 1)'(1);
	assign recip    = bin_mode_q ? RECIP_MAX : ewbh_pkg::RECIP_FEW;
	assign prod     = PROD_W'(span) * PROD_W'(recip);

	// Only one finished data set may wait for its bank to be read out.
	assign last_busy = (v_s1 && last_s1) || (v_s2 && last_s2) || (state_q == ST_DRAIN);
	assign req_stall = (state_q == ST_CLEAR) || (req.last_sample && last_busy);
	assign req_acc   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= req_acc;
			v_s2 <= v_s1;
			if (req_acc && req.last_sample) begin
				bank_q <= !bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		en_s1    <= in_range;
		last_s1  <= req.last_sample;
		bank_s1  <= bank_q;
		mode_s1  <= bin_mode_q;
		dist_s1  <= diff_x[SMP_W-1:0];
		width_s1 <= prod[ewbh_pkg::RECIP_SHIFT +: WID_W];
	end

	// Stage 1: the bin is the number of inner edges at or below the sample.
	// A zero width puts every edge at the low end, so all land in the top bin.
	logic [IDX_W-1:0] bin_k;

	always_comb begin
		bin_k = '0;
		for (int i = 1; i < MAX_BINS; i++) begin
			if ((mode_s1 || i < ewbh_pkg::FEW_BINS) &&
			    (EDGE_W'(i) * EDGE_W'(width_s1) <= EDGE_W'(dist_s1))) begin
				bin_k = bin_k + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		en_s2   <= en_s1;
		last_s2 <= last_s1;
		bank_s2 <= bank_s1;
		mode_s2 <= mode_s1;
		bin_s2  <= bin_k;
	end

	// Stage 2: increment. The write of the previous cycle is not yet visible
	// in the read data, so it is forwarded.
	logic             fwd_hit, s2_write;
	logic [CNT_W-1:0] cnt_old, cnt_new;

	assign fwd_hit  = fwd_v_q && (fwd_bank_q == bank_s2) && (fwd_addr_q == bin_s2);
	assign cnt_old  = fwd_hit ? fwd_data_q : ram_rdata[bank_s2];
	assign cnt_new  = cnt_old + 1'b1;
	assign s2_write = v_s2 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= s2_write;
		end
	end

	always_ff @(posedge clk) begin
		fwd_bank_q <= bank_s2;
		fwd_addr_q <= bin_s2;
		fwd_data_q <= cnt_new;
	end

	// Read-out of a finished bank: each step reads one counter and clears it.
	logic       pop, emit_j, credit_ok, step;
	logic [1:0] occ;

	assign pop    = out_v_q && !rsp_stall;
	assign occ    = {1'b0, out_v_q} + {1'b0, skid_v_q} + {1'b0, infl_v_q};
	assign credit_ok = (occ < 2'd2) || ((occ == 2'd2) && pop);
	assign emit_j = drain_mode_q || (32'(ptr_q) < ewbh_pkg::FEW_BINS);
	assign step   = (state_q == ST_DRAIN) && (!emit_j || credit_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			drain_bank_q <= 1'b0;
			drain_mode_q <= 1'b0;
			infl_v_q     <= 1'b0;
		end else begin
			infl_v_q <= step && emit_j;
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_PTR) begin
						ptr_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (v_s2 && last_s2) begin
						state_q      <= ST_DRAIN;
						ptr_q        <= '0;
						drain_bank_q <= bank_s2;
						drain_mode_q <= mode_s2;
					end
				end
				ST_DRAIN: begin
					if (step) begin
						ptr_q <= ptr_q + 1'b1;
						if (ptr_q == LAST_PTR) begin
							ptr_q   <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ptr_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		infl_bank_q <= drain_bank_q;
		infl_idx_q  <= ptr_q;
		infl_last_q <= drain_mode_q ? (ptr_q == LAST_PTR) : (ptr_q == LAST_PTR_FEW);
	end

	// Counter banks
	for (genvar r = 0; r < 2; r++) begin : g_bank
		always_comb begin
			ram_we[r]    = 1'b0;
			ram_waddr[r] = bin_s2;
			ram_wdata[r] = cnt_new;
			if (state_q == ST_CLEAR) begin
				ram_we[r]    = 1'b1;
				ram_waddr[r] = ptr_q;
				ram_wdata[r] = '0;
			end else if (step && (drain_bank_q == 1'(r))) begin
				ram_we[r]    = 1'b1;
				ram_waddr[r] = ptr_q;
				ram_wdata[r] = '0;
			end else if (s2_write && (bank_s2 == 1'(r))) begin
				ram_we[r] = 1'b1;
			end
			ram_raddr[r] = ((state_q == ST_DRAIN) && (drain_bank_q == 1'(r))) ? ptr_q : bin_k;
		end

		ewbh_ram #(
			.WIDTH(CNT_W),
			.DEPTH(MAX_BINS)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[r]),
			.waddr(ram_waddr[r]),
			.wdata(ram_wdata[r]),
			.raddr(ram_raddr[r]),
			.rdata(ram_rdata[r])
		);
	end

	// Two-entry output buffer
	always_comb begin
		push_data.bin_index = BIN_W'(infl_idx_q);
		push_data.bin_count = ram_rdata[infl_bank_q];
		push_data.last_bin  = infl_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= infl_v_q;
			end else begin
				out_v_q <= infl_v_q;
			end
		end else if (infl_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (infl_v_q) begin
			skid_q <= push_data;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule
